// ===== src/assert_macros.svh =====
// assertion helpers included by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssd assertion failed");

// next-cycle implication, disabled while reset is low
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssd assertion failed");

`endif

// ===== src/ssd_pkg.sv =====
package ssd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int PC_W = 6;

  // command codes
  localparam logic [3:0] OP_INIT    = 4'd0;
  localparam logic [3:0] OP_CHAR    = 4'd1;
  localparam logic [3:0] OP_NUMBER  = 4'd2;
  localparam logic [3:0] OP_POINT   = 4'd3;
  localparam logic [3:0] OP_TIME    = 4'd4;
  localparam logic [3:0] OP_ENABLE  = 4'd5;
  localparam logic [3:0] OP_REFRESH = 4'd6;
  localparam logic [3:0] OP_BRIGHT  = 4'd7;
  localparam logic [3:0] OP_SLEEP   = 4'd8;

  // driver register addresses
  localparam logic [3:0] REG_COL1     = 4'd1;
  localparam logic [3:0] REG_COL2     = 4'd2;
  localparam logic [3:0] REG_POINTS   = 4'd3;
  localparam logic [3:0] REG_COL4     = 4'd4;
  localparam logic [3:0] REG_COL5     = 4'd5;
  localparam logic [3:0] REG_COL6     = 4'd6;
  localparam logic [3:0] REG_COL7     = 4'd7;
  localparam logic [3:0] REG_COL8     = 4'd8;
  localparam logic [3:0] REG_DECODE   = 4'd9;
  localparam logic [3:0] REG_BRIGHT   = 4'd10;
  localparam logic [3:0] REG_SCAN     = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN = 4'd12;

  // glyph table indexes beyond the decimal digits
  localparam logic [3:0] GLYPH_DASH   = 4'd10;
  localparam logic [3:0] GLYPH_BLANK  = 4'd11;
  localparam logic [3:0] GLYPH_T      = 4'd12;
  localparam logic [3:0] GLYPH_L      = 4'd13;
  localparam logic [3:0] GLYPH_E      = 4'd14;
  localparam logic [3:0] GLYPH_DEGREE = 4'd15;

  // program entry points
  localparam logic [PC_W-1:0] PC_INIT    = 6'd0;
  localparam logic [PC_W-1:0] PC_CHAR    = 6'd12;
  localparam logic [PC_W-1:0] PC_NUMBER  = 6'd13;
  localparam logic [PC_W-1:0] PC_POINT   = 6'd19;
  localparam logic [PC_W-1:0] PC_TIME    = 6'd21;
  localparam logic [PC_W-1:0] PC_ENABLE  = 6'd22;
  localparam logic [PC_W-1:0] PC_REFRESH = 6'd23;
  localparam logic [PC_W-1:0] PC_BRIGHT  = 6'd30;
  localparam logic [PC_W-1:0] PC_SLEEP   = 6'd31;
  localparam logic [PC_W-1:0] PC_NOP     = 6'd33;
  localparam logic [PC_W-1:0] PC_LAST    = 6'd33;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_SET_CHAR,
    ACT_LOAD_NUM,
    ACT_DIV10,
    ACT_PLACE_NUM,
    ACT_SET_POINT,
    ACT_SET_TIME,
    ACT_APPLY_MASK
  } act_t;

  typedef enum logic [2:0] {
    DS_CONST,
    DS_COLUMN,
    DS_POINTS,
    DS_BRIGHT_DEF,
    DS_BRIGHT_REQ,
    DS_SLEEP
  } dsel_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_END,
    SQ_FLUSH,
    SQ_RANGE,
    SQ_IF_INIT
  } seq_t;

  typedef struct packed {
    act_t       act;
    logic       emit;
    logic [3:0] addr;
    dsel_t      dsel;
    logic [7:0] kdata;
    seq_t       seq;
  } ucode_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  char_code;
    logic [2:0]  position;
    logic [15:0] number;
    logic        point_on;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [3:0]  digit_enable;
    logic        flush;
    logic [7:0]  brightness;
    logic        sleep_on;
  } in_item_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } out_item_t;

  function automatic logic [7:0] glyph_lut(input logic [3:0] idx);
    logic [7:0] g;
    unique case (idx)
      4'd0:         g = 8'hDB;
      4'd1:         g = 8'h03;
      4'd2:         g = 8'hB9;
      4'd3:         g = 8'hB3;
      4'd4:         g = 8'h63;
      4'd5:         g = 8'hF2;
      4'd6:         g = 8'hFA;
      4'd7:         g = 8'h13;
      4'd8:         g = 8'hFB;
      4'd9:         g = 8'hF3;
      GLYPH_DASH:   g = 8'h20;
      GLYPH_BLANK:  g = 8'h00;
      GLYPH_T:      g = 8'hE8;
      GLYPH_L:      g = 8'hC8;
      GLYPH_E:      g = 8'hF8;
      GLYPH_DEGREE: g = 8'h71;
      default:      g = 8'h00;
    endcase
    return g;
  endfunction

  // column bit that each digit drives in the driver's column registers
  function automatic logic [7:0] column_bit(input logic [1:0] d);
    logic [7:0] b;
    unique case (d)
      2'd0:    b = 8'h08;
      2'd1:    b = 8'h80;
      2'd2:    b = 8'h02;
      2'd3:    b = 8'h40;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] g;
    if (c >= 8'h30 && c <= 8'h39) g = glyph_lut(4'(c - 8'h30));
    else if (c == 8'h4C)          g = glyph_lut(GLYPH_L);
    else if (c == 8'h54)          g = glyph_lut(GLYPH_T);
    else if (c == 8'h45)          g = glyph_lut(GLYPH_E);
    else if (c == 8'h2A)          g = glyph_lut(GLYPH_DEGREE);
    else if (c == 8'h20)          g = glyph_lut(GLYPH_BLANK);
    else                          g = glyph_lut(GLYPH_DASH);
    return g;
  endfunction

  function automatic ucode_t uw(input act_t act, input logic emit, input logic [3:0] addr,
                                input dsel_t dsel, input logic [7:0] kdata, input seq_t seq);
    ucode_t w;
    w.act   = act;
    w.emit  = emit;
    w.addr  = addr;
    w.dsel  = dsel;
    w.kdata = kdata;
    w.seq   = seq;
    return w;
  endfunction

  // microcode program, one control word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // init: decode off, scan all, wake, clear columns, default brightness
      6'd0:  w = uw(ACT_CLEAR, 1'b1, REG_DECODE, DS_CONST, 8'd0, SQ_NEXT);
      6'd1:  w = uw(ACT_NONE, 1'b1, REG_SCAN, DS_CONST, 8'd7, SQ_NEXT);
      6'd2:  w = uw(ACT_NONE, 1'b1, REG_SHUTDOWN, DS_CONST, 8'd1, SQ_NEXT);
      6'd3:  w = uw(ACT_NONE, 1'b1, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd4:  w = uw(ACT_NONE, 1'b1, REG_COL2, DS_CONST, 8'd0, SQ_NEXT);
      6'd5:  w = uw(ACT_NONE, 1'b1, REG_POINTS, DS_CONST, 8'd0, SQ_NEXT);
      6'd6:  w = uw(ACT_NONE, 1'b1, REG_COL4, DS_CONST, 8'd0, SQ_NEXT);
      6'd7:  w = uw(ACT_NONE, 1'b1, REG_COL5, DS_CONST, 8'd0, SQ_NEXT);
      6'd8:  w = uw(ACT_NONE, 1'b1, REG_COL6, DS_CONST, 8'd0, SQ_NEXT);
      6'd9:  w = uw(ACT_NONE, 1'b1, REG_COL7, DS_CONST, 8'd0, SQ_NEXT);
      6'd10: w = uw(ACT_NONE, 1'b1, REG_COL8, DS_CONST, 8'd0, SQ_NEXT);
      6'd11: w = uw(ACT_NONE, 1'b1, REG_BRIGHT, DS_BRIGHT_DEF, 8'd0, SQ_END);
      // char
      6'd12: w = uw(ACT_SET_CHAR, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_FLUSH);
      // number: load, four digit steps, place
      6'd13: w = uw(ACT_LOAD_NUM, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_RANGE);
      6'd14: w = uw(ACT_DIV10, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd15: w = uw(ACT_DIV10, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd16: w = uw(ACT_DIV10, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd17: w = uw(ACT_DIV10, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd18: w = uw(ACT_PLACE_NUM, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_FLUSH);
      // point
      6'd19: w = uw(ACT_SET_POINT, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd20: w = uw(ACT_NONE, 1'b1, REG_POINTS, DS_POINTS, 8'd0, SQ_END);
      // time, then enable mask, then fall into refresh
      6'd21: w = uw(ACT_SET_TIME, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      6'd22: w = uw(ACT_APPLY_MASK, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_NEXT);
      // refresh: seven column registers, points column skipped
      6'd23: w = uw(ACT_NONE, 1'b1, REG_COL1, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd24: w = uw(ACT_NONE, 1'b1, REG_COL2, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd25: w = uw(ACT_NONE, 1'b1, REG_COL4, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd26: w = uw(ACT_NONE, 1'b1, REG_COL5, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd27: w = uw(ACT_NONE, 1'b1, REG_COL6, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd28: w = uw(ACT_NONE, 1'b1, REG_COL7, DS_COLUMN, 8'd0, SQ_NEXT);
      6'd29: w = uw(ACT_NONE, 1'b1, REG_COL8, DS_COLUMN, 8'd0, SQ_END);
      // brightness
      6'd30: w = uw(ACT_NONE, 1'b1, REG_BRIGHT, DS_BRIGHT_REQ, 8'd0, SQ_END);
      // sleep, only once initialized
      6'd31: w = uw(ACT_NONE, 1'b0, REG_SHUTDOWN, DS_CONST, 8'd0, SQ_IF_INIT);
      6'd32: w = uw(ACT_NONE, 1'b1, REG_SHUTDOWN, DS_SLEEP, 8'd0, SQ_END);
      default: w = uw(ACT_NONE, 1'b0, REG_COL1, DS_CONST, 8'd0, SQ_END);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [3:0] op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_INIT:    pc = PC_INIT;
      OP_CHAR:    pc = PC_CHAR;
      OP_NUMBER:  pc = PC_NUMBER;
      OP_POINT:   pc = PC_POINT;
      OP_TIME:    pc = PC_TIME;
      OP_ENABLE:  pc = PC_ENABLE;
      OP_REFRESH: pc = PC_REFRESH;
      OP_BRIGHT:  pc = PC_BRIGHT;
      OP_SLEEP:   pc = PC_SLEEP;
      default:    pc = PC_NOP;
    endcase
    return pc;
  endfunction

endpackage

// ===== src/ssd_datapath.sv =====
module ssd_datapath import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_go,
  input  ucode_t     ctl,
  input  in_item_t   item,
  input  logic [3:0] default_brightness,
  output logic [7:0] wr_data,
  output logic       initialized
);

  logic [7:0]  patterns_r [DIGIT_COUNT];
  logic [7:0]  time_r [DIGIT_COUNT];
  logic [7:0]  points_r;
  logic        init_r;
  logic [15:0] work_r;
  logic [3:0]  digits_r [DIGIT_COUNT];

  logic [31:0] div_prod;
  logic [15:0] div_q;
  logic [15:0] div_rem;
  logic [7:0]  ntmp [DIGIT_COUNT];
  logic [14:0] m_prod, h_prod;
  logic [3:0]  mt, ht;
  logic [6:0]  mu_full, hu_full;
  logic [7:0]  tnew [DIGIT_COUNT];
  logic [2:0]  col_idx;
  logic [7:0]  col_data;
  logic [1:0]  pos2;
  logic [7:0]  pbit;

  assign pos2 = item.position[1:0];
  assign pbit = column_bit(pos2);

  // divide by ten through the reciprocal, exact for every 16-bit value
  always_comb begin
    div_prod = work_r * 32'd52429;
    div_q    = 16'(div_prod[31:19]);
    div_rem  = work_r - {div_q[12:0], 3'b000} - {div_q[14:0], 1'b0};
  end

  // right-aligned number glyphs with leading blanking, dash on overflow
  always_comb begin
    if (item.number <= 16'd9999) begin
      ntmp[0] = (digits_r[3] != 4'd0) ? glyph_lut(digits_r[3]) : glyph_lut(GLYPH_BLANK);
      ntmp[1] = (digits_r[3] != 4'd0 || digits_r[2] != 4'd0) ?
                glyph_lut(digits_r[2]) : glyph_lut(GLYPH_BLANK);
      ntmp[2] = (digits_r[3] != 4'd0 || digits_r[2] != 4'd0 || digits_r[1] != 4'd0) ?
                glyph_lut(digits_r[1]) : glyph_lut(GLYPH_BLANK);
      ntmp[3] = glyph_lut(digits_r[0]);
    end else begin
      ntmp[0] = glyph_lut(GLYPH_BLANK);
      ntmp[1] = glyph_lut(GLYPH_BLANK);
      ntmp[2] = glyph_lut(GLYPH_BLANK);
      ntmp[3] = glyph_lut(GLYPH_DASH);
    end
  end

  // hour and minute split into tens and units
  always_comb begin
    m_prod  = item.minute * 15'd205;
    h_prod  = item.hour * 15'd205;
    mt      = m_prod[14:11];
    ht      = h_prod[14:11];
    mu_full = item.minute - 7'({mt, 3'b000}) - 7'({mt, 1'b0});
    hu_full = item.hour - 7'({ht, 3'b000}) - 7'({ht, 1'b0});
    tnew[3] = glyph_lut(mu_full[3:0]);
    tnew[2] = (mt < 4'd9) ? glyph_lut(mt) : glyph_lut(GLYPH_DASH);
    tnew[1] = glyph_lut(hu_full[3:0]);
    if (ht >= 4'd9)      tnew[0] = glyph_lut(GLYPH_DASH);
    else if (ht == 4'd0) tnew[0] = glyph_lut(GLYPH_BLANK);
    else                 tnew[0] = glyph_lut(ht);
  end

  // transpose one segment row into a column register
  always_comb begin
    col_idx  = ctl.addr[2:0] - 3'd1;
    col_data = 8'd0;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (patterns_r[d][col_idx]) col_data = col_data | column_bit(2'(d));
    end
  end

  // write data select
  always_comb begin
    unique case (ctl.dsel)
      DS_CONST:      wr_data = ctl.kdata;
      DS_COLUMN:     wr_data = col_data;
      DS_POINTS:     wr_data = points_r;
      DS_BRIGHT_DEF: wr_data = {4'd0, default_brightness};
      DS_BRIGHT_REQ: wr_data = (item.brightness > 8'd15) ? 8'd15 : item.brightness;
      DS_SLEEP:      wr_data = item.sleep_on ? 8'd0 : 8'd1;
      default:       wr_data = 8'd0;
    endcase
  end

  assign initialized = init_r;

  // display state updates per microcode action
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        patterns_r[d] <= 8'd0;
        time_r[d]     <= 8'd0;
      end
      points_r <= 8'd0;
      init_r   <= 1'b0;
    end else if (step_go) begin
      unique case (ctl.act)
        ACT_NONE: begin
        end
        ACT_CLEAR: begin
          for (int d = 0; d < DIGIT_COUNT; d++) begin
            patterns_r[d] <= 8'd0;
            time_r[d]     <= 8'd0;
          end
          points_r <= 8'd0;
          init_r   <= 1'b1;
        end
        ACT_SET_CHAR: begin
          if (!item.position[2] && item.char_code != 8'd0)
            patterns_r[pos2] <= glyph_of(item.char_code);
        end
        ACT_LOAD_NUM: begin
        end
        ACT_DIV10: begin
        end
        ACT_PLACE_NUM: begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (2'(i) <= pos2) patterns_r[i] <= ntmp[2'd3 - pos2 + 2'(i)];
          end
        end
        ACT_SET_POINT: begin
          if (!item.position[2])
            points_r <= item.point_on ? (points_r | pbit) : (points_r & ~pbit);
        end
        ACT_SET_TIME: begin
          for (int d = 0; d < DIGIT_COUNT; d++) time_r[d] <= tnew[d];
        end
        ACT_APPLY_MASK: begin
          for (int d = 0; d < DIGIT_COUNT; d++)
            patterns_r[d] <= item.digit_enable[d] ? time_r[d] : glyph_lut(GLYPH_BLANK);
        end
        default: begin
        end
      endcase
    end
  end

  // number conversion work registers, one decimal digit per step
  always_ff @(posedge clk) begin
    if (step_go && ctl.act == ACT_LOAD_NUM) begin
      work_r <= item.number;
    end else if (step_go && ctl.act == ACT_DIV10) begin
      work_r <= div_q;
      digits_r[DIGIT_COUNT-1] <= div_rem[3:0];
      for (int d = 0; d < DIGIT_COUNT - 1; d++) digits_r[d] <= digits_r[d+1];
    end
  end

endmodule

// ===== src/seven_segment_display_controller.sv =====
// channel  | direction | handshake        | payload
// in_      | input     | in_valid/stall   | in_item_t   (one command)
// out_     | output    | out_valid/stall  | out_item_t  (one register write)
// cfg_     | input     | cfg_we           | default brightness, 4 bits
//
// one microcode word per unstalled cycle; init 12 steps, refresh 7, number 6
// (1 past the last digit), time 9, enable 8, char 1, point 2, sleep 2 (1
// before init), others 1; char and number add the 7 refresh steps when flushed.
// a command keeps in_stall high until its last step has been taken.
// synchronous active-low reset clears the sequencer, display state and output.
// while out_stall holds a pending write the step counter stays put.
module seven_segment_display_controller import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_payload,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload,
  input  logic      cfg_we,
  input  logic [3:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  in_item_t        item_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_payload_r;
  logic [3:0]      default_brightness_r;
  ucode_t          ctl;
  logic            out_free;
  logic            step_go;
  logic            in_xfer;
  logic [7:0]      wr_data;
  logic            initialized;

  assign ctl      = ucode_rom(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign step_go  = busy_r && out_free;
  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;

  ssd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_go            (step_go),
    .ctl                (ctl),
    .item               (item_r),
    .default_brightness (default_brightness_r),
    .wr_data            (wr_data),
    .initialized        (initialized)
  );

  // sequencer next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry_pc(in_payload.op);
    end else if (step_go) begin
      case (ctl.seq)
        SQ_NEXT: pc_nxt = pc_r + 6'd1;
        SQ_END:  busy_nxt = 1'b0;
        SQ_FLUSH: begin
          if (item_r.flush) pc_nxt = PC_REFRESH;
          else              busy_nxt = 1'b0;
        end
        SQ_RANGE: begin
          if (item_r.position[2]) busy_nxt = 1'b0;
          else                    pc_nxt = pc_r + 6'd1;
        end
        SQ_IF_INIT: begin
          if (initialized) pc_nxt = pc_r + 6'd1;
          else             busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_go && ctl.emit)       out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r               <= 1'b0;
      pc_r                 <= PC_NOP;
      out_valid_r          <= 1'b0;
      default_brightness_r <= 4'd8;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) default_brightness_r <= cfg_wdata;
    end
  end

  // command capture and write payload
  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_payload;
    if (step_go && ctl.emit) begin
      out_payload_r.reg_addr <= ctl.addr;
      out_payload_r.reg_data <= wr_data;
      out_payload_r.last     <= (ctl.seq == SQ_END);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  `SSD_ASSERT_NEXT(a_xfer_starts_program, clk, rst_n, in_xfer, busy_r)
  `SSD_ASSERT_NEXT(a_emit_fills_output, clk, rst_n, step_go && ctl.emit, out_valid_r)
  `SSD_ASSERT_NEXT(a_stall_holds_pc, clk, rst_n, busy_r && !out_free, $stable(pc_r))
  `SSD_ASSERT_NOW(a_pc_in_program, clk, rst_n, busy_r, pc_r <= PC_LAST)

endmodule

// ===== verif/seven_segment_display_checker.sv =====
module seven_segment_display_checker import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_payload,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_payload,
  input  logic      cfg_we,
  input  logic [3:0] cfg_wdata,
  output int        mismatches,
  output int        writes_pending
);

  // shadow of the display state
  logic [7:0] shown [DIGIT_COUNT];
  logic [7:0] saved_time [DIGIT_COUNT];
  logic [7:0] point_cols;
  logic       is_initialized;
  logic [3:0] init_brightness;

  // register writes still owed by the block, oldest first
  out_item_t expected_writes [$];
  out_item_t burst [12];
  int        burst_len;
  out_item_t oldest;
  int        fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic [7:0] glyph(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:         g = 8'hDB;
      4'd1:         g = 8'h03;
      4'd2:         g = 8'hB9;
      4'd3:         g = 8'hB3;
      4'd4:         g = 8'h63;
      4'd5:         g = 8'hF2;
      4'd6:         g = 8'hFA;
      4'd7:         g = 8'h13;
      4'd8:         g = 8'hFB;
      4'd9:         g = 8'hF3;
      GLYPH_DASH:   g = 8'h20;
      GLYPH_BLANK:  g = 8'h00;
      GLYPH_T:      g = 8'hE8;
      GLYPH_L:      g = 8'hC8;
      GLYPH_E:      g = 8'hF8;
      default:      g = 8'h71;
    endcase
    return g;
  endfunction

  // bit that a digit owns inside every column register
  function automatic logic [7:0] digit_col(input int d);
    logic [7:0] b;
    case (d)
      0:       b = 8'h08;
      1:       b = 8'h80;
      2:       b = 8'h02;
      default: b = 8'h40;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] char_glyph(input logic [7:0] c);
    logic [7:0] g;
    if (c >= "0" && c <= "9") g = glyph(c[3:0]);
    else if (c == "L")        g = glyph(GLYPH_L);
    else if (c == "T")        g = glyph(GLYPH_T);
    else if (c == "E")        g = glyph(GLYPH_E);
    else if (c == "*")        g = glyph(GLYPH_DEGREE);
    else if (c == " ")        g = glyph(GLYPH_BLANK);
    else                      g = glyph(GLYPH_DASH);
    return g;
  endfunction

  task add_write(input logic [3:0] addr, input logic [7:0] data);
    burst[burst_len] = '{reg_addr: addr, reg_data: data, last: 1'b0};
    burst_len++;
  endtask

  // transpose the four patterns into the seven column registers
  task add_refresh();
    logic [7:0] v;
    for (int col = 1; col <= 8; col++) begin
      if (col == REG_POINTS) continue;
      v = '0;
      for (int d = 0; d < DIGIT_COUNT; d++)
        if (shown[d][col-1]) v |= digit_col(d);
      add_write(col[3:0], v);
    end
  endtask

  task mask_digits(input logic [3:0] enable);
    for (int d = 0; d < DIGIT_COUNT; d++)
      shown[d] = enable[d] ? saved_time[d] : glyph(GLYPH_BLANK);
  endtask

  // update the shadow state for one command and queue the writes it causes
  task predict_writes(input in_item_t c);
    logic [7:0] digits [4];
    int th, hu, te, un, mt, ht;
    out_item_t w;
    burst_len = 0;
    case (c.op)
      OP_INIT: begin
        add_write(REG_DECODE, 8'd0);
        add_write(REG_SCAN, 8'd7);
        add_write(REG_SHUTDOWN, 8'd1);
        for (int col = 1; col <= 8; col++) add_write(col[3:0], 8'd0);
        add_write(REG_BRIGHT, {4'd0, init_brightness});
        for (int d = 0; d < DIGIT_COUNT; d++) begin
          shown[d] = '0;
          saved_time[d] = '0;
        end
        point_cols = '0;
        is_initialized = 1'b1;
      end
      OP_CHAR: begin
        if (c.position < DIGIT_COUNT && c.char_code != 8'd0)
          shown[c.position] = char_glyph(c.char_code);
        if (c.flush) add_refresh();
      end
      OP_NUMBER: begin
        if (c.number <= 16'd9999) begin
          th = c.number / 1000;
          hu = (c.number / 100) % 10;
          te = (c.number / 10) % 10;
          un = c.number % 10;
          digits[0] = (th != 0) ? glyph(th[3:0]) : glyph(GLYPH_BLANK);
          digits[1] = (th != 0 || hu != 0) ? glyph(hu[3:0]) : glyph(GLYPH_BLANK);
          digits[2] = (th != 0 || hu != 0 || te != 0) ? glyph(te[3:0]) : glyph(GLYPH_BLANK);
          digits[3] = glyph(un[3:0]);
        end else begin
          digits[0] = glyph(GLYPH_BLANK);
          digits[1] = glyph(GLYPH_BLANK);
          digits[2] = glyph(GLYPH_BLANK);
          digits[3] = glyph(GLYPH_DASH);
        end
        // out-of-range end position: no change and no writes
        if (c.position < DIGIT_COUNT) begin
          for (int d = 0; d < 4 && d <= c.position; d++)
            shown[c.position - d] = digits[3 - d];
          if (c.flush) add_refresh();
        end
      end
      OP_POINT: begin
        if (c.position < DIGIT_COUNT) begin
          if (c.point_on) point_cols = point_cols | digit_col(c.position);
          else point_cols = point_cols & ~digit_col(c.position);
        end
        add_write(REG_POINTS, point_cols);
      end
      OP_TIME: begin
        un = c.minute % 10;
        mt = c.minute / 10;
        saved_time[3] = glyph(un[3:0]);
        saved_time[2] = (mt < 9) ? glyph(mt[3:0]) : glyph(GLYPH_DASH);
        un = c.hour % 10;
        ht = c.hour / 10;
        saved_time[1] = glyph(un[3:0]);
        if (ht >= 9) saved_time[0] = glyph(GLYPH_DASH);
        else if (ht == 0) saved_time[0] = glyph(GLYPH_BLANK);
        else saved_time[0] = glyph(ht[3:0]);
        mask_digits(c.digit_enable);
        add_refresh();
      end
      OP_ENABLE: begin
        mask_digits(c.digit_enable);
        add_refresh();
      end
      OP_REFRESH: add_refresh();
      OP_BRIGHT: add_write(REG_BRIGHT, (c.brightness > 8'd15) ? 8'd15 : c.brightness);
      OP_SLEEP: begin
        // ignored until the first init
        if (is_initialized) add_write(REG_SHUTDOWN, c.sleep_on ? 8'd0 : 8'd1);
      end
      default: ;
    endcase
    for (int i = 0; i < burst_len; i++) begin
      w = burst[i];
      w.last = (i == burst_len - 1);
      expected_writes.push_back(w);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        shown[d] = '0;
        saved_time[d] = '0;
      end
      point_cols = '0;
      is_initialized = 1'b0;
      init_brightness = 4'd8;
      expected_writes.delete();
    end else begin
      if (cfg_we) init_brightness = cfg_wdata;
      if (in_valid && !in_stall) predict_writes(in_payload);
      // compare each result transfer with the oldest expected write
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write addr %0d data %02h last %0b", $time,
                   out_payload.reg_addr, out_payload.reg_data, out_payload.last);
          fail_count++;
        end else begin
          oldest = expected_writes.pop_front();
          if (out_payload.reg_addr !== oldest.reg_addr) begin
            $display("%0t: reg_addr expected %0d actual %0d", $time,
                     oldest.reg_addr, out_payload.reg_addr);
            fail_count++;
          end
          if (out_payload.reg_data !== oldest.reg_data) begin
            $display("%0t: reg_data expected %02h actual %02h", $time,
                     oldest.reg_data, out_payload.reg_data);
            fail_count++;
          end
          if (out_payload.last !== oldest.last) begin
            $display("%0t: last expected %0b actual %0b", $time,
                     oldest.last, out_payload.last);
            fail_count++;
          end
        end
      end
    end
    writes_pending <= expected_writes.size();
  end

endmodule

// ===== verif/seven_segment_display_controller_test.sv =====
module seven_segment_display_controller_test;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  // longest program is 13 steps; commands without writes may still be running
  localparam int SETTLE_CYCLES = 40;
  localparam logic [3:0] OP_SPARE_FIRST = 4'd9;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_payload = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_payload;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int mismatches;
  int writes_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_display_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  seven_segment_display_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_payload    (out_payload),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .writes_pending (writes_pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_item_t random_cmd();
    in_item_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) c.op = OP_INIT;
    else if (pick < 7) c.op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else c.op = 4'($urandom_range(OP_CHAR, OP_SLEEP));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.char_code = 8'($urandom_range("0", "9"));
      4: begin
        case ($urandom_range(0, 4))
          0:       c.char_code = "L";
          1:       c.char_code = "T";
          2:       c.char_code = "E";
          3:       c.char_code = "*";
          default: c.char_code = " ";
        endcase
      end
      5:       c.char_code = 8'd0;
      default: c.char_code = 8'($urandom);
    endcase
    c.position = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    pick = $urandom_range(0, 9);
    if (pick < 3) c.number = 16'($urandom_range(0, 99));
    else if (pick < 7) c.number = 16'($urandom_range(0, 9999));
    else c.number = 16'($urandom);
    c.point_on = 1'($urandom);
    c.hour = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    c.minute = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    c.digit_enable = 4'($urandom);
    c.flush = ($urandom_range(0, 3) != 0);
    c.brightness = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 16)) : 8'($urandom);
    c.sleep_on = 1'($urandom);
    return c;
  endfunction

  // one command transfer; valid only drops when the sender idles
  task automatic send_cmd(input in_item_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // directed command: arg lands in the field that the op uses
  task automatic command(input logic [3:0] op, input logic [17:0] arg,
                         input logic [2:0] pos, input logic fl);
    in_item_t c;
    c = random_cmd();
    c.op = op;
    c.position = pos;
    c.flush = fl;
    case (op)
      OP_CHAR:   c.char_code = arg[7:0];
      OP_NUMBER: c.number = arg[15:0];
      OP_POINT:  c.point_on = arg[0];
      OP_TIME:   {c.digit_enable, c.minute, c.hour} = arg;
      OP_ENABLE: c.digit_enable = arg[3:0];
      OP_BRIGHT: c.brightness = arg[7:0];
      OP_SLEEP:  c.sleep_on = arg[0];
      default: ;
    endcase
    send_cmd(c);
  endtask

  // hold off until every expected write has arrived
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (writes_pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_default_brightness(input logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmds(input int count);
    in_item_t c;
    int sent;
    sent = 0;
    while (sent < count) begin
      c = random_cmd();
      send_cmd(c);
      if (c.op <= OP_SLEEP) sent++;
      if ($urandom_range(0, 24) == 0) drain(0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_default_brightness(4'd15);

    // sender idles often, receiver nearly always stalls
    send_idle_pct = 38;
    recv_idle_pct = 85;

    // directed: sleep before init and spare op do nothing
    command(OP_SLEEP, 18'd1, 3'd0, 1'b0);
    command(OP_SPARE_FIRST, 18'd0, 3'd0, 1'b0);
    command(OP_INIT, 18'd0, 3'd0, 1'b0);
    // every glyph class, zero code, unknown code, position past the digits
    command(OP_CHAR, "8", 3'd0, 1'b1);
    command(OP_CHAR, "L", 3'd1, 1'b0);
    command(OP_CHAR, "T", 3'd2, 1'b0);
    command(OP_CHAR, "E", 3'd3, 1'b1);
    command(OP_CHAR, "*", 3'd0, 1'b0);
    command(OP_CHAR, " ", 3'd1, 1'b0);
    command(OP_CHAR, 18'd0, 3'd2, 1'b1);
    command(OP_CHAR, 18'hFF, 3'd3, 1'b1);
    command(OP_CHAR, "5", 3'd7, 1'b1);
    // numbers: zero, digits dropped at the left, overflow dash, bad position
    command(OP_NUMBER, 18'd0, 3'd3, 1'b1);
    command(OP_NUMBER, 18'd9999, 3'd1, 1'b1);
    command(OP_NUMBER, 18'd65535, 3'd3, 1'b1);
    command(OP_NUMBER, 18'd7, 3'd4, 1'b1);
    // points, including a position past the digits
    command(OP_POINT, 18'd1, 3'd0, 1'b0);
    command(OP_POINT, 18'd1, 3'd6, 1'b0);
    command(OP_POINT, 18'd0, 3'd0, 1'b0);
    // time: blank hour tens, dash tens, partial enable
    command(OP_TIME, {4'b1111, 7'd0, 7'd0}, 3'd0, 1'b0);
    command(OP_TIME, {4'b1111, 7'd127, 7'd127}, 3'd0, 1'b0);
    command(OP_TIME, {4'b0101, 7'd59, 7'd23}, 3'd0, 1'b0);
    command(OP_ENABLE, 18'b1010, 3'd0, 1'b0);
    command(OP_BRIGHT, 18'd255, 3'd0, 1'b0);
    command(OP_SLEEP, 18'd1, 3'd0, 1'b0);
    command(OP_SLEEP, 18'd0, 3'd0, 1'b0);
    random_cmds(28);

    // sender nearly always idles, receiver stalls often
    drain(SETTLE_CYCLES);
    write_default_brightness(4'd0);
    send_idle_pct = 85;
    recv_idle_pct = 38;
    command(OP_INIT, 18'd0, 3'd0, 1'b0);
    random_cmds(28);

    // full rate on both sides
    drain(SETTLE_CYCLES);
    write_default_brightness(4'($urandom_range(1, 14)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    command(OP_INIT, 18'd0, 3'd0, 1'b0);
    random_cmds(27);

    drain(SETTLE_CYCLES);
    if (mismatches == 0 && writes_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
